// ===== rtl/icv_pkg.sv =====
// package: shared types, constants and crc byte fold for the image crc check
`timescale 1ns / 1ps

package icv_pkg;

    localparam int unsigned CRC_W  = 32;
    localparam int unsigned DATA_W = 16;
    localparam int unsigned BYTE_W = 8;

    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

    typedef struct packed {
        logic [DATA_W-1:0] data_word;
        logic              last_word;
    } t_word;

    typedef struct packed {
        logic [CRC_W-1:0] crc_value;
        logic             verify_ok;
    } t_result;

    // reflected crc-32, one byte, eight bit steps
    function automatic logic [CRC_W-1:0] fold_byte(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] byte_in
    );
        logic [CRC_W-1:0] crc;
        crc = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, byte_in};
        for (int k = 0; k < BYTE_W; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// ===== rtl/icv_if.sv =====
// interfaces: input word channel and result channel
`timescale 1ns / 1ps

interface icv_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] data_word;
    logic        last_word;

    modport source (output valid, output data_word, output last_word, input ready);
    modport sink   (input valid, input data_word, input last_word, output ready);
endinterface

interface icv_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] crc_value;
    logic        verify_ok;

    modport source (output valid, output crc_value, output verify_ok, input ready);
    modport sink   (input valid, input crc_value, input verify_ok, output ready);
endinterface

// ===== rtl/icv_in_stage.sv =====
// input register stage for image words
`timescale 1ns / 1ps

module icv_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  icv_pkg::t_word i_word,
    output logic          o_valid,
    output icv_pkg::t_word o_word,
    input  logic          i_take
);

    logic           r_valid;
    logic           n_valid;
    icv_pkg::t_word r_word;

    assign o_ready = !r_valid || i_take;
    assign n_valid = o_ready ? i_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ===== rtl/icv_crc_core.sv =====
// crc accumulator, final compare and result register
`timescale 1ns / 1ps

module icv_crc_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  icv_pkg::t_word                i_word,
    output logic                          o_take,
    input  logic [icv_pkg::CRC_W-1:0]     i_expected,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output icv_pkg::t_result              o_res
);

    logic [icv_pkg::CRC_W-1:0] r_crc;
    logic [icv_pkg::CRC_W-1:0] n_crc;
    logic [icv_pkg::CRC_W-1:0] crc_lo;
    logic [icv_pkg::CRC_W-1:0] crc_mid;
    logic [icv_pkg::CRC_W-1:0] crc_fin;
    logic                      out_free;
    logic                      fin_take;
    logic                      r_res_valid;
    logic                      n_res_valid;
    icv_pkg::t_result          r_res;

    assign out_free = !r_res_valid || i_res_ready;
    assign o_take   = i_valid && (!i_word.last_word || out_free);
    assign fin_take = o_take && i_word.last_word;

    // low byte first, then high byte
    assign crc_lo  = icv_pkg::fold_byte(r_crc, i_word.data_word[7:0]);
    assign crc_mid = icv_pkg::fold_byte(crc_lo, i_word.data_word[15:8]);
    assign crc_fin = ~crc_mid;

    always_comb begin
        n_crc = r_crc;
        if (o_take) begin
            n_crc = i_word.last_word ? icv_pkg::CRC_INIT : crc_mid;
        end
    end

    always_comb begin
        n_res_valid = r_res_valid;
        if (fin_take) begin
            n_res_valid = 1'b1;
        end else if (i_res_ready) begin
            n_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= icv_pkg::CRC_INIT;
            r_res_valid <= 1'b0;
        end else begin
            r_crc       <= n_crc;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_take) begin
            r_res.crc_value <= crc_fin;
            r_res.verify_ok <= (crc_fin == i_expected);
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// ===== rtl/image_crc32_verify.sv =====
// top level: streaming crc-32 check of a 16-bit word image
//
//   channel   dir   handshake      payload
//   i_in      in    valid/ready    data_word[15:0], last_word
//   o_out     out   valid/ready    crc_value[31:0], verify_ok
//   cfg       in    i_cfg_we       i_cfg_wdata[31:0] (expected crc)
//
// one word per cycle unless stalled; input stage and result are registered
// the throughput is set by the single crc accumulator update per cycle
// synchronous active-low reset sets the crc to all ones and expected crc to 0
// a result waiting in the output register stalls only a word marked last
`timescale 1ns / 1ps

module image_crc32_verify (
    input  logic               i_clk,
    input  logic               i_rst_n,
    icv_in_if.sink             i_in,
    icv_out_if.source          o_out,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_wdata
);

    logic [icv_pkg::CRC_W-1:0] r_expected;
    icv_pkg::t_word            in_word;
    icv_pkg::t_word            stg_word;
    logic                      stg_valid;
    logic                      stg_take;
    icv_pkg::t_result          res;
    logic                      res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= '0;
        end else if (i_cfg_we) begin
            r_expected <= i_cfg_wdata;
        end
    end

    assign in_word.data_word = i_in.data_word;
    assign in_word.last_word = i_in.last_word;

    icv_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_word  (in_word),
        .o_valid (stg_valid),
        .o_word  (stg_word),
        .i_take  (stg_take)
    );

    icv_crc_core u_crc_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (stg_valid),
        .i_word      (stg_word),
        .o_take      (stg_take),
        .i_expected  (r_expected),
        .o_res_valid (res_valid),
        .i_res_ready (o_out.ready),
        .o_res       (res)
    );

    assign o_out.valid     = res_valid;
    assign o_out.crc_value = res.crc_value;
    assign o_out.verify_ok = res.verify_ok;

endmodule

// ===== bench/testbench.sv =====
// testbench: crc-32 image check against a running predictor, random stalls on both sides
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned RANDOM_WORDS = 900;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned IDLE_PCT     = 17;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [icv_pkg::CRC_W-1:0] cfg_wdata;

    icv_in_if  in_ch ();
    icv_out_if out_ch ();

    image_crc32_verify dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    logic [icv_pkg::CRC_W-1:0]  crc_running;
    logic [icv_pkg::CRC_W-1:0]  expected_crc_copy;
    icv_pkg::t_result           crc_due [$];
    logic [icv_pkg::DATA_W-1:0] image_words [$];
    int unsigned                error_count  = 0;
    int unsigned                words_sent   = 0;
    int unsigned                cycle_count  = 0;
    int unsigned                rx_hold_left = 0;
    bit                         tx_idle_en   = 1'b1;
    bit                         rx_idle_en   = 1'b1;

    // reflected crc, word bits taken lsb first (low byte, then high byte)
    function automatic logic [icv_pkg::CRC_W-1:0] crc_fold_word(
        input logic [icv_pkg::CRC_W-1:0]  crc_in,
        input logic [icv_pkg::DATA_W-1:0] word
    );
        logic [icv_pkg::CRC_W-1:0] crc;
        logic                      fb;
        crc = crc_in;
        for (int b = 0; b < icv_pkg::DATA_W; b++) begin
            fb  = crc[0] ^ word[b];
            crc = crc >> 1;
            if (fb) begin
                crc = crc ^ icv_pkg::CRC_POLY;
            end
        end
        return crc;
    endfunction

    function automatic logic [icv_pkg::CRC_W-1:0] image_crc();
        logic [icv_pkg::CRC_W-1:0] crc;
        crc = icv_pkg::CRC_INIT;
        foreach (image_words[i]) begin
            crc = crc_fold_word(crc, image_words[i]);
        end
        return ~crc;
    endfunction

    task automatic predict_word(input logic [icv_pkg::DATA_W-1:0] data, input logic last);
        logic [icv_pkg::CRC_W-1:0] crc;
        icv_pkg::t_result          res;
        crc = crc_fold_word(crc_running, data);
        if (last) begin
            res.crc_value = ~crc;
            res.verify_ok = (res.crc_value == expected_crc_copy);
            crc_due.push_back(res);
            crc_running = icv_pkg::CRC_INIT;
        end else begin
            crc_running = crc;
        end
    endtask

    task automatic send_word(input logic [icv_pkg::DATA_W-1:0] data, input logic last);
        if (tx_idle_en && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_word <= data;
        in_ch.last_word <= last;
        do @(posedge clk); while (!in_ch.ready);
        predict_word(data, last);
        words_sent++;
    endtask

    task automatic send_image();
        foreach (image_words[i]) begin
            send_word(image_words[i], i == image_words.size() - 1);
        end
    endtask

    task automatic build_image(input int unsigned len);
        image_words.delete();
        repeat (len) image_words.push_back(16'($urandom()));
    endtask

    // wait until the block has nothing left in flight
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (crc_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_expected_crc(input logic [icv_pkg::CRC_W-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        expected_crc_copy = value;
        cfg_we <= 1'b0;
    endtask

    task automatic test_reset_value();
        send_word(16'h1234, 1'b1);
    endtask

    task automatic test_single_word_images();
        logic [icv_pkg::DATA_W-1:0] pats [6];
        pats = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h5555, 16'hAAAA};
        foreach (pats[i]) begin
            send_word(pats[i], 1'b1);
        end
    endtask

    task automatic test_crc_match();
        build_image(4);
        write_expected_crc(image_crc());
        send_image();
        write_expected_crc(32'hFFFF_FFFF);
        send_word(16'hFFFF, 1'b1);
        write_expected_crc(32'h0000_0000);
        build_image(2);
        send_image();
    endtask

    task automatic test_expected_change_mid_image();
        build_image(4);
        for (int i = 0; i < 3; i++) begin
            send_word(image_words[i], 1'b0);
        end
        write_expected_crc(image_crc());
        send_word(image_words[3], 1'b1);
    endtask

    task automatic test_output_stall();
        settle();
        rx_hold_left = HOLD_CYCLES;
        repeat (30) send_word(16'($urandom()), $urandom_range(3) != 0);
        settle();
    endtask

    task automatic test_random_images();
        int unsigned stop_at;
        int unsigned phase;
        int unsigned pick;
        int unsigned len;
        stop_at = words_sent + RANDOM_WORDS;
        phase   = 0;
        while (words_sent < stop_at) begin
            phase++;
            // quiet stretch with no idling on either side
            tx_idle_en = !(phase >= 20 && phase < 35);
            rx_idle_en = tx_idle_en;
            pick = $urandom_range(9);
            len  = ($urandom_range(9) == 0) ? $urandom_range(8, 32) : $urandom_range(1, 6);
            build_image(len);
            if (pick == 0 && len > 1) begin
                for (int i = 0; i < len - 1; i++) begin
                    send_word(image_words[i], 1'b0);
                end
                write_expected_crc(image_crc());
                send_word(image_words[len-1], 1'b1);
            end else begin
                if (pick < 5) begin
                    write_expected_crc(image_crc());
                end else if (pick == 5) begin
                    write_expected_crc(32'h0000_0000);
                end else if (pick == 6) begin
                    write_expected_crc(32'hFFFF_FFFF);
                end else begin
                    write_expected_crc($urandom());
                end
                send_image();
            end
            repeat ($urandom_range(0, 4)) begin
                build_image($urandom_range(1, 5));
                send_image();
            end
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // result side: check each accepted result, then drive ready for the next cycle
    initial begin
        icv_pkg::t_result want;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready) begin
                if (crc_due.size() == 0) begin
                    $display("%0t unexpected result: crc_value %h verify_ok %b",
                             $time, out_ch.crc_value, out_ch.verify_ok);
                    error_count++;
                end else begin
                    want = crc_due.pop_front();
                    if (out_ch.crc_value !== want.crc_value) begin
                        $display("%0t crc_value mismatch: expected %h actual %h",
                                 $time, want.crc_value, out_ch.crc_value);
                        error_count++;
                    end
                    if (out_ch.verify_ok !== want.verify_ok) begin
                        $display("%0t verify_ok mismatch: expected %b actual %b",
                                 $time, want.verify_ok, out_ch.verify_ok);
                        error_count++;
                    end
                end
            end
            if (rx_hold_left != 0) begin
                rx_hold_left--;
                out_ch.ready <= 1'b0;
            end else if (rx_idle_en) begin
                out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, crc_due.size());
        $display("FAILURE");
        $finish;
    end

    initial begin
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.data_word <= '0;
        in_ch.last_word <= 1'b0;
        crc_running       = icv_pkg::CRC_INIT;
        expected_crc_copy = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_value();
        test_single_word_images();
        test_crc_match();
        test_expected_change_mid_image();
        test_output_stall();
        test_random_images();

        settle();
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/icv_pkg.sv
rtl/icv_if.sv
rtl/icv_in_stage.sv
rtl/icv_crc_core.sv
rtl/image_crc32_verify.sv
bench/testbench.sv
